// ===== rtl/core/htv_pkg.sv =====
package htv_pkg;

  localparam int DataW     = 32;
  localparam int EpsW      = 16;
  localparam int LenW      = 31;
  localparam int Lanes     = 3;
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 32;

  // operation codes
  typedef enum logic [3:0] {
    FN_NEG       = 4'd0,
    FN_ADD       = 4'd1,
    FN_SUB       = 4'd2,
    FN_SCALE     = 4'd3,
    FN_DIV       = 4'd4,
    FN_MAG       = 4'd5,
    FN_NORM      = 4'd6,
    FN_EQUAL     = 4'd7,
    FN_IS_POINT  = 4'd8,
    FN_IS_VECTOR = 4'd9
  } func_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_OK                = 3'd0,
    ERR_ADD_POINTS        = 3'd1,
    ERR_POINT_FROM_VECTOR = 3'd2,
    ERR_DIV_ZERO          = 3'd3,
    ERR_NORM_ZERO         = 3'd4
  } err_t;

  // request context carried down the pipeline
  typedef struct packed {
    logic [3:0]                  func;
    err_t                        err;
    logic                        truth;
    logic [3:0][DataW-1:0]       r;
    logic [LenW-1:0]             len;
    logic [Lanes-1:0][DataW-1:0] aabs;
    logic [Lanes-1:0]            aneg;
    logic [DataW-1:0]            sabs;
    logic                        sneg;
  } side_t;

  // magnitude of a two's complement word
  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // magnitude and sign to saturated signed word
  function automatic logic [31:0] sat_sign(input logic big, input logic [31:0] mag,
                                           input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (big || (mag > 32'h8000_0000)) ? 32'h8000_0000 : (~mag + 32'd1);
    end else begin
      res = (big || mag[31]) ? 32'h7FFF_FFFF : mag;
    end
    return res;
  endfunction

  // 33-bit signed sum to saturated word
  function automatic logic [31:0] sat33(input logic [32:0] s);
    logic [31:0] res;
    if (s[32] != s[31]) begin
      res = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = s[31:0];
    end
    return res;
  endfunction

  // tolerant compare on an exact difference
  function automatic logic near(input logic [33:0] d, input logic [EpsW-1:0] eps);
    logic [33:0] m;
    m = d[33] ? (~d + 34'd1) : d;
    return m < {18'd0, eps};
  endfunction

endpackage

// ===== rtl/core/htv_front.sv =====
module htv_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [3:0]          func,
  input  logic [31:0]         ax,
  input  logic [31:0]         ay,
  input  logic [31:0]         az,
  input  logic [31:0]         aw,
  input  logic [31:0]         bx,
  input  logic [31:0]         by_comp,
  input  logic [31:0]         bz,
  input  logic [31:0]         bw,
  input  logic [31:0]         scalar,
  input  logic [15:0]         eps,
  output logic                vld,
  output htv_pkg::side_t      side,
  output logic [63:0]         sq
);

  logic [3:0][31:0] av, bv;
  htv_pkg::side_t   s1_next, s1, s2, s3_next;
  logic             vld1, vld2;
  logic [2:0][63:0] p2_next, p2;
  logic [63:0]      sq_next;

  assign av = {aw, az, ay, ax};
  assign bv = {bw, bz, by_comp, bx};

  // decode, simple operations, error checks and tests
  always_comb begin
    logic [3:0][32:0] sum, dif;
    s1_next       = '0;
    s1_next.func  = func;
    s1_next.err   = htv_pkg::ERR_OK;
    s1_next.sabs  = htv_pkg::abs32(scalar);
    s1_next.sneg  = scalar[31];
    for (int i = 0; i < 3; i++) begin
      s1_next.aabs[i] = htv_pkg::abs32(av[i]);
      s1_next.aneg[i] = av[i][31];
    end
    for (int i = 0; i < 4; i++) begin
      sum[i] = {av[i][31], av[i]} + {bv[i][31], bv[i]};
      dif[i] = {av[i][31], av[i]} - {bv[i][31], bv[i]};
    end
    case (func)
      htv_pkg::FN_NEG: begin
        for (int i = 0; i < 3; i++) begin
          s1_next.r[i] = htv_pkg::sat_sign(1'b0, s1_next.aabs[i], !av[i][31]);
        end
        s1_next.r[3] = aw;
      end
      htv_pkg::FN_ADD: begin
        if (htv_pkg::near({sum[3][32], sum[3]} - 34'h2_0000, eps)) begin
          s1_next.err = htv_pkg::ERR_ADD_POINTS;
        end else begin
          for (int i = 0; i < 4; i++) s1_next.r[i] = htv_pkg::sat33(sum[i]);
        end
      end
      htv_pkg::FN_SUB: begin
        if (dif[3][32]) begin
          s1_next.err = htv_pkg::ERR_POINT_FROM_VECTOR;
        end else begin
          for (int i = 0; i < 4; i++) s1_next.r[i] = htv_pkg::sat33(dif[i]);
        end
      end
      htv_pkg::FN_SCALE: begin
        s1_next.r[3] = aw;
      end
      htv_pkg::FN_DIV: begin
        if (s1_next.sabs == 32'd0 || s1_next.sabs < {16'd0, eps}) begin
          s1_next.err = htv_pkg::ERR_DIV_ZERO;
        end else begin
          s1_next.r[3] = aw;
        end
      end
      htv_pkg::FN_MAG: begin
      end
      htv_pkg::FN_NORM: begin
        s1_next.r[3] = aw;
      end
      htv_pkg::FN_EQUAL: begin
        s1_next.truth = htv_pkg::near({dif[0][32], dif[0]}, eps) &&
                        htv_pkg::near({dif[1][32], dif[1]}, eps) &&
                        htv_pkg::near({dif[2][32], dif[2]}, eps) &&
                        htv_pkg::near({dif[3][32], dif[3]}, eps);
      end
      htv_pkg::FN_IS_POINT: begin
        s1_next.truth = htv_pkg::near({{2{aw[31]}}, aw} - 34'h1_0000, eps);
      end
      htv_pkg::FN_IS_VECTOR: begin
        s1_next.truth = htv_pkg::near({{2{aw[31]}}, aw}, eps);
      end
      default: begin
      end
    endcase
  end

  // shared multipliers: products for scale, squares otherwise
  always_comb begin
    logic [31:0] op;
    op = (s1.func == htv_pkg::FN_SCALE) ? s1.sabs : 32'd0;
    for (int i = 0; i < 3; i++) begin
      if (s1.func != htv_pkg::FN_SCALE) op = s1.aabs[i];
      p2_next[i] = {32'd0, s1.aabs[i]} * {32'd0, op};
    end
  end

  // rounding of scaled products and sum of squares
  always_comb begin
    logic [63:0] rnd;
    logic [47:0] m;
    s3_next = s2;
    rnd     = '0;
    m       = '0;
    if (s2.func == htv_pkg::FN_SCALE) begin
      for (int i = 0; i < 3; i++) begin
        rnd = p2[i] + 64'h8000;
        m   = rnd[63:16];
        s3_next.r[i] = htv_pkg::sat_sign(|m[47:32], m[31:0], s2.aneg[i] ^ s2.sneg);
      end
    end
    sq_next = p2[0] + p2[1] + p2[2];
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld  <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld  <= vld2;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= s1_next;
      s2   <= s1;
      p2   <= p2_next;
      side <= s3_next;
      sq   <= sq_next;
    end
  end

endmodule

// ===== rtl/core/htv_sqrt.sv =====
module htv_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_vld,
  input  logic [63:0]    val_in,
  input  htv_pkg::side_t side_in,
  output logic           vld,
  output logic [31:0]    root,
  output htv_pkg::side_t side
);

  localparam int N = htv_pkg::SqrtSteps;

  logic           vld_q  [0:N-1];
  logic [35:0]    rem_q  [0:N-1];
  logic [31:0]    root_q [0:N-1];
  logic [63:0]    val_q  [0:N-1];
  htv_pkg::side_t side_q [0:N-1];

  // one result bit per stage, two radicand bits consumed
  for (genvar k = 0; k < N; k++) begin : g_step
    logic           vld_p;
    logic [35:0]    rem_p;
    logic [31:0]    root_p;
    logic [63:0]    val_p;
    htv_pkg::side_t side_p;
    logic [35:0]    rem_sh, trial;
    logic           take;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rem_p  = '0;
      assign root_p = '0;
      assign val_p  = val_in;
      assign side_p = side_in;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign val_p  = val_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign rem_sh = {rem_p[33:0], val_p[63:62]};
    assign trial  = {2'b00, root_p, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_p[30:0], take};
        val_q[k]  <= {val_p[61:0], 2'b00};
        side_q[k] <= side_p;
      end
    end
  end

  assign vld  = vld_q[N-1];
  assign root = root_q[N-1];
  assign side = side_q[N-1];

endmodule

// ===== rtl/core/htv_div.sv =====
module htv_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [31:0]      divisor,
  input  htv_pkg::side_t   side_in,
  output logic             vld,
  output logic [2:0][31:0] quo,
  output logic [2:0]       big,
  output htv_pkg::side_t   side
);

  localparam int N = htv_pkg::DivSteps;

  logic             vld0;
  logic [31:0]      d0;
  logic [2:0][31:0] rem0, low0, rem0_next, low0_next;
  logic [2:0]       big0, big0_next;
  htv_pkg::side_t   side0;

  logic             vld_q  [0:N-1];
  logic [31:0]      d_q    [0:N-1];
  logic [2:0][31:0] rem_q  [0:N-1];
  logic [2:0][31:0] low_q  [0:N-1];
  logic [2:0][31:0] quo_q  [0:N-1];
  logic [2:0]       big_q  [0:N-1];
  htv_pkg::side_t   side_q [0:N-1];

  // rounded dividend and overflow check
  always_comb begin
    logic [47:0] num;
    num = '0;
    for (int i = 0; i < 3; i++) begin
      num          = {side_in.aabs[i], 16'd0} + {17'd0, divisor[31:1]};
      big0_next[i] = {16'd0, num[47:32]} >= divisor;
      rem0_next[i] = {16'd0, num[47:32]};
      low0_next[i] = num[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0    <= divisor;
      rem0  <= rem0_next;
      low0  <= low0_next;
      big0  <= big0_next;
      side0 <= side_in;
    end
  end

  // restoring division, one quotient bit per stage in each lane
  for (genvar k = 0; k < N; k++) begin : g_step
    logic             vld_p;
    logic [31:0]      d_p;
    logic [2:0][31:0] rem_p, low_p, quo_p;
    logic [2:0]       big_p;
    htv_pkg::side_t   side_p;
    logic [2:0][31:0] rem_n, low_n, quo_n;

    if (k == 0) begin : g_first
      assign vld_p  = vld0;
      assign d_p    = d0;
      assign rem_p  = rem0;
      assign low_p  = low0;
      assign quo_p  = '0;
      assign big_p  = big0;
      assign side_p = side0;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign d_p    = d_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign low_p  = low_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign big_p  = big_q[k-1];
      assign side_p = side_q[k-1];
    end

    always_comb begin
      logic [32:0] t, diff;
      logic        ge;
      t    = '0;
      diff = '0;
      ge   = 1'b0;
      for (int i = 0; i < 3; i++) begin
        t        = {rem_p[i], low_p[i][31]};
        diff     = t - {1'b0, d_p};
        ge       = t >= {1'b0, d_p};
        rem_n[i] = ge ? diff[31:0] : t[31:0];
        low_n[i] = {low_p[i][30:0], 1'b0};
        quo_n[i] = {quo_p[i][30:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_q[k]    <= d_p;
        rem_q[k]  <= rem_n;
        low_q[k]  <= low_n;
        quo_q[k]  <= quo_n;
        big_q[k]  <= big_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign vld  = vld_q[N-1];
  assign quo  = quo_q[N-1];
  assign big  = big_q[N-1];
  assign side = side_q[N-1];

endmodule

// ===== rtl/core/homogeneous_tuple_vector_unit_top.sv =====
// path: a request runs through the front, square root, divider and output registers
// throughput: one request per cycle; the 32-stage square root and 32-stage divider
// take one result bit per stage, and a held result freezes the whole pipeline
// reset: synchronous rst clears every stage valid bit and the output valid, and
// sets epsilon to 1
module homogeneous_tuple_vector_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  func,
  input  logic [31:0] ax,
  input  logic [31:0] ay,
  input  logic [31:0] az,
  input  logic [31:0] aw,
  input  logic [31:0] bx,
  input  logic [31:0] by_comp,
  input  logic [31:0] bz,
  input  logic [31:0] bw,
  input  logic [31:0] scalar,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] rx,
  output logic [31:0] ry,
  output logic [31:0] rz,
  output logic [31:0] rw,
  output logic [30:0] length,
  output logic        truth,
  output logic [2:0]  error,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic             adv;
  logic [15:0]      epsilon;
  logic             fr_vld, sq_vld, dv_vld;
  htv_pkg::side_t   fr_side, sq_side, mid_side, dv_side;
  logic [63:0]      fr_sq;
  logic [31:0]      root, divisor;
  logic [2:0][31:0] quo;
  logic [2:0]       big;
  logic [3:0][31:0] res;

  // pipeline moves when the output register is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= 16'd1;
    end else if (cfg_we) begin
      epsilon <= cfg_wdata;
    end
  end

  htv_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (in_valid),
    .func    (func),
    .ax      (ax),
    .ay      (ay),
    .az      (az),
    .aw      (aw),
    .bx      (bx),
    .by_comp (by_comp),
    .bz      (bz),
    .bw      (bw),
    .scalar  (scalar),
    .eps     (epsilon),
    .vld     (fr_vld),
    .side    (fr_side),
    .sq      (fr_sq)
  );

  htv_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (fr_vld),
    .val_in  (fr_sq),
    .side_in (fr_side),
    .vld     (sq_vld),
    .root    (root),
    .side    (sq_side)
  );

  // magnitude result, zero-length check and divisor choice
  always_comb begin
    mid_side = sq_side;
    divisor  = (sq_side.func == htv_pkg::FN_DIV) ? sq_side.sabs : root;
    if (sq_side.func == htv_pkg::FN_MAG) begin
      mid_side.len = root[31] ? 31'h7FFF_FFFF : root[30:0];
    end
    if (sq_side.func == htv_pkg::FN_NORM &&
        (root == 32'd0 || root < {16'd0, epsilon})) begin
      mid_side.err = htv_pkg::ERR_NORM_ZERO;
    end
  end

  htv_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (sq_vld),
    .divisor (divisor),
    .side_in (mid_side),
    .vld     (dv_vld),
    .quo     (quo),
    .big     (big),
    .side    (dv_side)
  );

  // quotient sign and saturation, zero tuple on error
  always_comb begin
    logic is_div, is_norm;
    is_div  = dv_side.func == htv_pkg::FN_DIV;
    is_norm = dv_side.func == htv_pkg::FN_NORM;
    res     = dv_side.r;
    if (is_div || is_norm) begin
      for (int i = 0; i < 3; i++) begin
        res[i] = htv_pkg::sat_sign(big[i], quo[i],
                                   dv_side.aneg[i] ^ (is_div && dv_side.sneg));
      end
    end
    if (dv_side.err != htv_pkg::ERR_OK) begin
      res = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx     <= res[0];
      ry     <= res[1];
      rz     <= res[2];
      rw     <= res[3];
      length <= dv_side.len;
      truth  <= dv_side.truth;
      error  <= dv_side.err;
    end
  end

endmodule

// ===== rtl/core/htv_checker.sv =====
module htv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rx,
  input logic [31:0] ry,
  input logic [31:0] rz,
  input logic [31:0] rw,
  input logic [30:0] length,
  input logic        truth,
  input logic [2:0]  error
);

  // an error result carries a zero tuple
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error != htv_pkg::ERR_OK |-> rx == 0 && ry == 0 && rz == 0 && rw == 0)
    else $error("error result with nonzero tuple");

  // a test answer comes alone
  a_truth_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && truth |-> error == htv_pkg::ERR_OK && length == 0 &&
                           rx == 0 && ry == 0 && rz == 0 && rw == 0)
    else $error("truth with other fields set");

  // a magnitude comes alone
  a_len_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && length != 0 |-> !truth && rx == 0 && ry == 0 && rz == 0 && rw == 0)
    else $error("length with other fields set");

  // a held result freezes the intake
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result held");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rx) && $stable(error) && $stable(length))
    else $error("held result changed");

endmodule

bind homogeneous_tuple_vector_unit_top htv_checker u_htv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .rx        (rx),
  .ry        (ry),
  .rz        (rz),
  .rw        (rw),
  .length    (length),
  .truth     (truth),
  .error     (error)
);
